/* rtl/core/lge_pkg.sv */
`default_nettype none

package lge_pkg;

	// Grid geometry
	localparam int GRID_W   = 128;
	localparam int GRID_H   = 128;
	localparam int COL_AW   = $clog2(GRID_W);
	localparam int ROW_AW   = $clog2(GRID_H);
	localparam int ROW_CW   = $clog2(GRID_H + 1);

	// Field and register widths
	localparam int FUNC_W   = 2;
	localparam int CFG_W    = 8;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

	// Register indexes (word address bit)
	localparam logic REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic REG_ACTIVE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST  = 8'd100;
	localparam logic [CFG_W-1:0] ACTIVE_HEIGHT_RST = 8'd100;

	// Neighbor counts of the B3/S23 rule
	localparam logic [3:0] LIFE_BORN_N = 4'd3;
	localparam logic [3:0] LIFE_KEEP_N = 4'd2;

	typedef logic [GRID_W-1:0] row_t;

	typedef struct packed {
		logic capture;
		logic cell_do;
		logic adv_rd;
		logic adv_wr;
		logic clear;
		logic out_load;
	} lge_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              adv_last;
		logic              out_free;
	} lge_sts_t;

	// Columns below the active width
	function automatic row_t col_mask(input logic [CFG_W-1:0] w);
		row_t m;
		for (int x = 0; x < GRID_W; x++) begin
			m[x] = (ROW_CW'(x) < ROW_CW'(w)) || (w > CFG_W'(GRID_W - 1));
		end
		return m;
	endfunction

	// Next generation of one row from its old neighbors; edges count as dead
	function automatic row_t life_row(input row_t up, input row_t mid, input row_t dn);
		row_t              res;
		logic [GRID_W+1:0] u;
		logic [GRID_W+1:0] m;
		logic [GRID_W+1:0] d;
		logic [3:0]        n;
		u = {1'b0, up, 1'b0};
		m = {1'b0, mid, 1'b0};
		d = {1'b0, dn, 1'b0};
		for (int x = 0; x < GRID_W; x++) begin
			n = 4'(u[x]) + 4'(u[x+1]) + 4'(u[x+2]) + 4'(m[x]) + 4'(m[x+2])
				+ 4'(d[x]) + 4'(d[x+1]) + 4'(d[x+2]);
			res[x] = (n == LIFE_BORN_N) || ((n == LIFE_KEEP_N) && m[x+1]);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lge_if.sv */
`default_nettype none

interface lge_in_if;
	import lge_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [COL_AW-1:0] cell_x;
	logic [ROW_AW-1:0] cell_y;
	logic              cell_value;
	modport source(output valid, func, cell_x, cell_y, cell_value, input ready);
	modport sink(input valid, func, cell_x, cell_y, cell_value, output ready);
endinterface

interface lge_out_if;
	import lge_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] done_func;
	logic              cell_state;
	modport source(output valid, done_func, cell_state, input ready);
	modport sink(input valid, done_func, cell_state, output ready);
endinterface

`default_nettype wire

/* rtl/core/lge_ctrl.sv */
`default_nettype none

module lge_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  lge_pkg::lge_sts_t sts,
	output lge_pkg::lge_cmd_t cmd
);
	import lge_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CELL_RD = 3'd1;
	localparam logic [2:0] S_CELL_DO = 3'd2;
	localparam logic [2:0] S_ADV_RD  = 3'd3;
	localparam logic [2:0] S_ADV_WR  = 3'd4;
	localparam logic [2:0] S_CLEAR   = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && in_ready;
		cmd.cell_do  = (state_q == S_CELL_DO);
		cmd.adv_rd   = (state_q == S_ADV_RD);
		cmd.adv_wr   = (state_q == S_ADV_WR);
		cmd.clear    = (state_q == S_CLEAR);
		cmd.out_load = (state_q == S_DONE) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (sts.func)
						FUNC_WRITE, FUNC_READ: state_d = S_CELL_RD;
						FUNC_ADVANCE:          state_d = S_ADV_RD;
						FUNC_CLEAR:            state_d = S_CLEAR;
						default:               state_d = S_CLEAR;
					endcase
				end
			end
			S_CELL_RD: state_d = S_CELL_DO;
			S_CELL_DO: state_d = S_DONE;
			S_ADV_RD:  state_d = S_ADV_WR;
			S_ADV_WR:  state_d = sts.adv_last ? S_DONE : S_ADV_RD;
			S_CLEAR:   state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q != S_IDLE)
		else $error("item accepted but controller stayed idle");

	a_adv_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADV_WR |-> $past(state_q) == S_ADV_RD)
		else $error("row write without a preceding row read");

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && sts.out_free) |=> state_q == S_IDLE)
		else $error("result loaded but controller not idle");

endmodule

`default_nettype wire

/* rtl/core/lge_datapath.sv */
`default_nettype none

module lge_datapath (
	input  wire                         clk,
	input  wire                         arst_n,
	input  lge_pkg::lge_cmd_t           cmd,
	output lge_pkg::lge_sts_t           sts,
	input  wire [lge_pkg::CFG_W-1:0]    active_width,
	input  wire [lge_pkg::CFG_W-1:0]    active_height,
	input  wire [lge_pkg::FUNC_W-1:0]   func,
	input  wire [lge_pkg::COL_AW-1:0]   cell_x,
	input  wire [lge_pkg::ROW_AW-1:0]   cell_y,
	input  wire                         cell_value,
	input  wire                         out_ready,
	output logic                        out_valid,
	output logic [lge_pkg::FUNC_W-1:0]  done_func,
	output logic                        cell_state
);
	import lge_pkg::*;

	// Row memory and per-row valid bits (invalid row reads as dead)
	row_t              mem [GRID_H];
	logic [GRID_H-1:0] row_valid_q;
	row_t              rd_data_q;
	logic              rd_valid_q;

	// Captured item
	logic [FUNC_W-1:0] func_q;
	logic [COL_AW-1:0] cx_q;
	logic [ROW_AW-1:0] cy_q;
	logic              cv_q;
	logic              result_q;

	// Advance sweep: row counter and three-row window
	logic [ROW_CW-1:0] r_q;
	row_t              prev_q;
	row_t              cur_q;

	logic              out_valid_q;
	logic [FUNC_W-1:0] done_func_q;
	logic              cell_state_q;

	row_t              cmask;
	row_t              rd_row;
	row_t              next_row;
	row_t              life_res;
	row_t              cell_row;
	logic              cell_inside;
	logic [ROW_AW-1:0] rd_addr;
	logic [ROW_AW-1:0] wr_addr;
	row_t              wr_data;
	logic              wr_en;
	logic [ROW_CW-1:0] r_prev;

	assign cmask       = col_mask(active_width);
	assign cell_inside = (CFG_W'(cx_q) < active_width) && (CFG_W'(cy_q) < active_height);
	assign rd_row      = rd_valid_q ? rd_data_q : '0;
	assign r_prev      = r_q - ROW_CW'(1);

	// Row below the current one, dead past the grid or the active height
	assign next_row = ((r_q < ROW_CW'(GRID_H)) && (CFG_W'(r_q) < active_height))
		? (rd_row & cmask) : '0;
	assign life_res = life_row(prev_q, cur_q, next_row);

	// Read-modify-write of one cell
	always_comb begin
		cell_row       = rd_row;
		cell_row[cx_q] = cv_q;
	end

	// Select memory addresses and write data
	always_comb begin
		rd_addr = cmd.adv_rd ? r_q[ROW_AW-1:0] : cy_q;
		if (cmd.adv_wr) begin
			wr_addr = r_prev[ROW_AW-1:0];
			wr_data = (CFG_W'(r_prev) < active_height) ? (life_res & cmask) : '0;
			wr_en   = (r_q != '0);
		end else begin
			wr_addr = cy_q;
			wr_data = cell_row;
			wr_en   = cmd.cell_do && (func_q == FUNC_WRITE) && cell_inside;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Valid bits: clear drops all rows at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= row_valid_q[rd_addr];
			if (cmd.clear) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Capture the item and run the sweep window
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			cx_q     <= cell_x;
			cy_q     <= cell_y;
			cv_q     <= cell_value;
			result_q <= 1'b0;
			prev_q   <= '0;
			cur_q    <= '0;
		end else begin
			if (cmd.cell_do && (func_q == FUNC_READ)) begin
				result_q <= cell_inside && rd_row[cx_q];
			end
			if (cmd.adv_wr) begin
				prev_q <= cur_q;
				cur_q  <= next_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
		end else if (cmd.capture) begin
			r_q <= '0;
		end else if (cmd.adv_wr) begin
			r_q <= r_q + ROW_CW'(1);
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			done_func_q  <= func_q;
			cell_state_q <= result_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign done_func    = done_func_q;
	assign cell_state   = cell_state_q;

	assign sts.func     = cmd.capture ? func : func_q;
	assign sts.adv_last = (r_q == ROW_CW'(GRID_H));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

/* rtl/core/life_grid_engine_core.sv */
// A cell write or read passes through the states CELL_RD, CELL_DO and DONE, a clear
// through CLEAR and DONE, and an advance through ADV_RD/ADV_WR pairs, then DONE.
// Throughput: one item at a time; an advance sweeps the grid one row per ADV_RD/ADV_WR
// pair through the row memory (read the row below, then write the new row).
// The next item is accepted as soon as the result sits in the output register.
// Reset: asynchronous, clears the per-row valid bits so the grid reads all dead at once.
`default_nettype none

module life_grid_engine_core (
	input  wire                          clk,
	input  wire                          arst_n,
	lge_in_if.sink                       in_ch,
	lge_out_if.source                    out_ch,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [lge_pkg::PADDR_W-1:0]   paddr,
	input  wire [lge_pkg::PDATA_W-1:0]   pwdata,
	output logic [lge_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import lge_pkg::*;

	logic [CFG_W-1:0] active_width_q;
	logic [CFG_W-1:0] active_height_q;
	lge_cmd_t         cmd;
	lge_sts_t         sts;
	logic             in_ready;

	assign pready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= ACTIVE_WIDTH_RST;
			active_height_q <= ACTIVE_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ACTIVE_WIDTH:  active_width_q  <= pwdata[CFG_W-1:0];
				REG_ACTIVE_HEIGHT: active_height_q <= pwdata[CFG_W-1:0];
				default:           active_width_q  <= active_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE_WIDTH:  prdata = PDATA_W'(active_width_q);
			REG_ACTIVE_HEIGHT: prdata = PDATA_W'(active_height_q);
			default:           prdata = '0;
		endcase
	end

	assign in_ch.ready = in_ready;

	lge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lge_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.active_width  (active_width_q),
		.active_height (active_height_q),
		.func          (in_ch.func),
		.cell_x        (in_ch.cell_x),
		.cell_y        (in_ch.cell_y),
		.cell_value    (in_ch.cell_value),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.done_func     (out_ch.done_func),
		.cell_state    (out_ch.cell_state)
	);

endmodule

`default_nettype wire
